// ===== rtl/chunked_slot_pool_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// chunked slot pool allocator assertion macros
// shared concurrent assertion helpers for the slot pool rtl
// ----------------------------------------------------------------------------
`ifndef CHUNKED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define CHUNKED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define CSPA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSPA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CSPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cspa_pkg.sv =====
// ----------------------------------------------------------------------------
// cspa_pkg
// shared codes and command/status structs for the slot pool allocator
// ----------------------------------------------------------------------------
`default_nettype none
package cspa_pkg;
  // opcodes
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_SPAWN   = 2'd1;
  localparam logic [1:0] OP_DESPAWN = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;
  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_CHUNKS  = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;
  // config register indexes
  localparam logic [1:0] REG_CHUNK_CAP = 2'd0;
  localparam logic [1:0] REG_POOL_CAP  = 2'd1;
  localparam logic [1:0] REG_INIT_CAP  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch input item
    logic init_step;  // write at most one stack entry, clear at most one bitmap row
    logic div_start;  // start division
    logic mem_rd;     // marks the bitmap row read state; the rams read on every clock
    logic commit;     // update state and result
  } cspa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic init_last;
    logic div_done;
  } cspa_stat_t;
endpackage
`default_nettype wire

// ===== rtl/chunked_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// chunked_slot_pool_allocator
// chunked entity slot pool with free-index stack and liveness bitmap
// ----------------------------------------------------------------------------
// usage:
//   raise start with opcode and pool_index while busy is low; the item is
//   taken at that edge and busy rises for the rest of its work.
//   one result comes back on the result ports with done high for exactly
//   one cycle; the receiver cannot hold it off.
//   spawn, despawn and query go through a stack read, a 12-step serial
//   divider by chunk capacity, a bitmap row read and a commit.
//   init refills the stack and clears the bitmap rows one entry per
//   cycle, then divides out the chunk count.
//   configuration is written through cfg_we, cfg_index, cfg_data while idle.
//   after rst the pool is empty with no free stack; spawns grow chunks.
//   the stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module chunked_slot_pool_allocator #(
  parameter int POOL_SLOTS      = 256,
  parameter int MAX_CHUNKS      = 16,
  parameter int MAX_CHUNK_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        start,
  input  wire logic [1:0]  opcode,
  input  wire logic [9:0]  pool_index,
  output logic             busy,
  output logic             done,
  output logic [2:0]       status,
  output logic [9:0]       slot_index,
  output logic [3:0]       chunk_number,
  output logic [5:0]       local_slot,
  output logic             is_alive,
  output logic [10:0]      live_count,
  output logic [4:0]       active_chunks
);
  cspa_pkg::cspa_cmd_t  cmd;
  cspa_pkg::cspa_stat_t stat;

  cspa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done)
  );

  cspa_datapath #(
    .POOL_SLOTS(POOL_SLOTS), .MAX_CHUNKS(MAX_CHUNKS), .MAX_CHUNK_SLOTS(MAX_CHUNK_SLOTS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .opcode(opcode), .pool_index(pool_index), .cmd(cmd), .stat(stat),
    .status(status), .slot_index(slot_index), .chunk_number(chunk_number),
    .local_slot(local_slot), .is_alive(is_alive), .live_count(live_count),
    .active_chunks(active_chunks)
  );
endmodule
`default_nettype wire

// ===== rtl/cspa_ram.sv =====
// ----------------------------------------------------------------------------
// cspa_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module cspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/cspa_datapath.sv =====
// ----------------------------------------------------------------------------
// cspa_datapath
// stack, liveness bitmap, chunk counters, divider and result registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "chunked_slot_pool_allocator_macros.svh"
module cspa_datapath #(
  parameter int POOL_SLOTS      = 256,
  parameter int MAX_CHUNKS      = 16,
  parameter int MAX_CHUNK_SLOTS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [10:0]          cfg_data,
  input  wire logic [1:0]           opcode,
  input  wire logic [9:0]           pool_index,
  input  wire cspa_pkg::cspa_cmd_t  cmd,
  output cspa_pkg::cspa_stat_t      stat,
  output logic [2:0]                status,
  output logic [9:0]                slot_index,
  output logic [3:0]                chunk_number,
  output logic [5:0]                local_slot,
  output logic                      is_alive,
  output logic [10:0]               live_count,
  output logic [4:0]                active_chunks
);
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int LW = (MAX_CHUNK_SLOTS > 1) ? $clog2(MAX_CHUNK_SLOTS) : 1;
  localparam int DW = $clog2(POOL_SLOTS + 1);
  localparam int NW = $clog2(MAX_CHUNKS + 1);
  localparam int HW = $clog2(MAX_CHUNK_SLOTS + 1);
  localparam int RW = (MAX_CHUNKS > 1) ? CW : 1;

  // config registers
  logic [6:0]  chunk_cap_reg;
  logic [8:0]  pool_cap_reg;
  logic [10:0] init_cap_reg;
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_cap_reg <= 7'd64;
      pool_cap_reg  <= 9'd256;
      init_cap_reg  <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cspa_pkg::REG_CHUNK_CAP: chunk_cap_reg <= cfg_data[6:0];
        cspa_pkg::REG_POOL_CAP:  pool_cap_reg  <= cfg_data[8:0];
        cspa_pkg::REG_INIT_CAP:  init_cap_reg  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped capacities
  logic [10:0] cc;
  logic [10:0] pc;
  always_comb begin
    cc = {4'd0, chunk_cap_reg};
    if (cc == 11'd0) cc = 11'd1;
    if (cc > 11'(MAX_CHUNK_SLOTS)) cc = 11'(MAX_CHUNK_SLOTS);
    pc = {2'd0, pool_cap_reg};
    if (pc == 11'd0) pc = 11'd1;
    if (pc > 11'(POOL_SLOTS)) pc = 11'(POOL_SLOTS);
  end

  // state
  logic [DW-1:0]          free_depth;
  logic [NW-1:0]          chunk_total;
  logic [4:0]             active_cnt;
  logic [10:0]            entity_total;
  logic [HW-1:0]          high_water [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0]  row_clean;   // row grown and not written since; reads as slot 0 only

  // latched item
  logic [1:0]  op_q;
  logic [9:0]  idx_q;

  // init sweep counter
  logic [DW-1:0] init_cnt;
  assign stat.init_last = (init_cnt + DW'(1) >= DW'(pc)) && (32'(init_cnt) + 1 >= MAX_CHUNKS);

  // serial restoring divider: 12-bit dividend by cc
  logic [11:0] div_num;
  logic [11:0] div_quo;
  logic [10:0] div_rem;
  logic [3:0]  div_cnt;
  logic        div_busy;
  logic [11:0] trial;
  assign trial = {div_rem, div_num[11]};
  assign stat.div_done = !div_busy;

  // decided index to work on
  logic        pop_case;
  logic [9:0]  tgt_idx;

  // stack memory
  logic          stk_we;
  logic [SW-1:0] stk_waddr;
  logic [9:0]    stk_wdata;
  logic [SW-1:0] stk_raddr;
  logic [9:0]    stk_rdata;
  cspa_ram #(.WIDTH(10), .DEPTH(POOL_SLOTS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // bitmap memory, one row per chunk
  logic                       bm_we;
  logic [RW-1:0]              bm_waddr;
  logic [MAX_CHUNK_SLOTS-1:0] bm_wdata;
  logic [RW-1:0]              bm_raddr;
  logic [MAX_CHUNK_SLOTS-1:0] bm_rdata;
  cspa_ram #(.WIDTH(MAX_CHUNK_SLOTS), .DEPTH((MAX_CHUNKS > 1) ? MAX_CHUNKS : 2)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  // quotient and remainder views
  logic [11:0] q_full;
  logic [5:0]  r_loc;
  logic [CW-1:0] q_ch;
  logic [LW-1:0] r_lw;
  assign q_full = div_quo;
  assign r_loc  = 6'(div_rem);
  assign q_ch   = CW'(div_quo);
  assign r_lw   = LW'(div_rem);

  // effective bitmap row: a freshly grown chunk holds only its slot 0
  logic [MAX_CHUNK_SLOTS-1:0] cur_row;
  assign cur_row = row_clean[q_ch] ? MAX_CHUNK_SLOTS'(1) : bm_rdata;

  // liveness of decided slot
  logic in_range;
  logic cur_alive;
  assign in_range  = (q_full < 12'(chunk_total)) && (q_full < 12'(MAX_CHUNKS));
  assign cur_alive = in_range && (HW'(div_rem) < high_water[q_ch]) && cur_row[r_lw];

  // memory address and write control
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = SW'(free_depth);
    stk_wdata = idx_q;
    stk_raddr = SW'(free_depth - DW'(1));
    bm_we     = 1'b0;
    bm_waddr  = RW'(q_ch);
    bm_wdata  = bm_rdata;
    bm_raddr  = RW'(q_ch);
    if (cmd.init_step) begin
      stk_we    = (init_cnt < DW'(pc));
      stk_waddr = SW'(DW'(pc) - DW'(1) - init_cnt);
      stk_wdata = 10'(init_cnt);
      bm_we     = (32'(init_cnt) < MAX_CHUNKS);
      bm_waddr  = RW'(init_cnt);
      bm_wdata  = '0;
    end else if (cmd.commit) begin
      if (op_q == cspa_pkg::OP_DESPAWN && cur_alive) begin
        bm_we     = 1'b1;
        bm_wdata  = cur_row;
        bm_wdata[r_lw] = 1'b0;
        stk_we    = (11'(free_depth) < pc);
      end else if (op_q == cspa_pkg::OP_SPAWN && pop_case && in_range) begin
        bm_we     = 1'b1;
        bm_wdata  = cur_row;
        bm_wdata[r_lw] = 1'b1;
      end
    end
  end

  // grow path
  logic grow_ok;
  assign grow_ok = 32'(chunk_total) < MAX_CHUNKS;

  // sequential state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth   <= '0;
      chunk_total  <= '0;
      active_cnt   <= '0;
      entity_total <= '0;
      div_busy     <= 1'b0;
      init_cnt     <= '0;
      row_clean    <= '0;
      for (int i = 0; i < MAX_CHUNKS; i++) high_water[i] <= '0;
    end else begin
      if (cmd.load) begin
        op_q     <= opcode;
        idx_q    <= pool_index;
        init_cnt <= '0;
        pop_case <= (opcode == cspa_pkg::OP_SPAWN) && (free_depth != '0);
      end
      if (cmd.init_step) begin
        init_cnt <= init_cnt + DW'(1);
      end
      // divider start: pop waits for stack read data
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= 4'd12;
        div_rem  <= '0;
        div_quo  <= '0;
        if (op_q == cspa_pkg::OP_INIT) begin
          div_num <= 12'(init_cap_reg) + 12'(cc) - 12'd1;
        end else if (pop_case) begin
          div_num <= {2'd0, stk_rdata};
          tgt_idx <= stk_rdata;
          free_depth <= free_depth - DW'(1);
        end else begin
          div_num <= {2'd0, idx_q};
          tgt_idx <= idx_q;
        end
      end else if (div_busy) begin
        div_num <= {div_num[10:0], 1'b0};
        if (trial >= 12'(cc)) begin
          div_rem <= 11'(trial - 12'(cc));
          div_quo <= {div_quo[10:0], 1'b1};
        end else begin
          div_rem <= 11'(trial);
          div_quo <= {div_quo[10:0], 1'b0};
        end
        div_cnt <= div_cnt - 4'd1;
        if (div_cnt == 4'd1) div_busy <= 1'b0;
      end
      // commit: update state and result
      if (cmd.commit) begin
        live_count    <= entity_total;
        active_chunks <= active_cnt;
        status        <= cspa_pkg::ST_OK;
        slot_index    <= tgt_idx;
        chunk_number  <= 4'(div_quo);
        local_slot    <= r_loc;
        is_alive      <= 1'b0;
        unique case (op_q)
          cspa_pkg::OP_INIT: begin
            slot_index   <= '0;
            chunk_number <= '0;
            local_slot   <= '0;
            if (div_quo == 12'd0) chunk_total <= NW'(1);
            else if (div_quo > 12'(MAX_CHUNKS)) chunk_total <= NW'(MAX_CHUNKS);
            else chunk_total <= NW'(div_quo);
            free_depth   <= DW'(pc);
            active_cnt   <= '0;
            entity_total <= '0;
            row_clean    <= '0;
            live_count   <= '0;
            active_chunks <= '0;
            for (int i = 0; i < MAX_CHUNKS; i++) high_water[i] <= '0;
          end
          cspa_pkg::OP_SPAWN: begin
            if (pop_case) begin
              if (!in_range) begin
                status <= cspa_pkg::ST_RANGE;
              end else begin
                is_alive <= 1'b1;
                row_clean[q_ch] <= 1'b0;
                if (HW'(div_rem) + HW'(1) > high_water[q_ch])
                  high_water[q_ch] <= HW'(div_rem) + HW'(1);
                if (5'(div_quo) + 5'd1 > active_cnt) begin
                  active_cnt    <= 5'(div_quo) + 5'd1;
                  active_chunks <= 5'(div_quo) + 5'd1;
                end
                if (entity_total < 11'd2047) begin
                  entity_total <= entity_total + 11'd1;
                  live_count   <= entity_total + 11'd1;
                end
              end
            end else begin
              slot_index   <= '0;
              chunk_number <= '0;
              local_slot   <= '0;
              if (entity_total < pc) begin
                if (!grow_ok) begin
                  status <= cspa_pkg::ST_CHUNKS;
                end else begin
                  // grow by one chunk and take its slot 0
                  chunk_total <= chunk_total + NW'(1);
                  active_cnt  <= 5'(chunk_total) + 5'd1;
                  active_chunks <= 5'(chunk_total) + 5'd1;
                  high_water[CW'(chunk_total)] <= HW'(1);
                  row_clean[CW'(chunk_total)] <= 1'b1;
                  slot_index   <= 10'(11'(chunk_total) * cc);
                  chunk_number <= 4'(chunk_total);
                  is_alive     <= 1'b1;
                  if (entity_total < 11'd2047) begin
                    entity_total <= entity_total + 11'd1;
                    live_count   <= entity_total + 11'd1;
                  end
                end
              end else begin
                status <= cspa_pkg::ST_FULL;
              end
            end
          end
          cspa_pkg::OP_DESPAWN: begin
            if (!cur_alive) begin
              status <= cspa_pkg::ST_IGNORED;
            end else begin
              row_clean[q_ch] <= 1'b0;
              if (entity_total != 11'd0) begin
                entity_total <= entity_total - 11'd1;
                live_count   <= entity_total - 11'd1;
              end
              if (11'(free_depth) < pc) free_depth <= free_depth + DW'(1);
            end
          end
          default: begin
            is_alive <= cur_alive;
          end
        endcase
      end
    end
  end

  // assertions
  `CSPA_ASSERT_IMPL(a_depth_bound, clk, rst, 1'b1, 32'(free_depth) <= POOL_SLOTS)
  `CSPA_ASSERT_IMPL(a_chunks_bound, clk, rst, 1'b1, 32'(chunk_total) <= MAX_CHUNKS)
  `CSPA_ASSERT_IMPL(a_active_bound, clk, rst, 1'b1, 32'(active_cnt) <= 32'(chunk_total))
endmodule
`default_nettype wire

// ===== rtl/cspa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cspa_ctrl
// sequencing state machine for one item at a time
// ----------------------------------------------------------------------------
`default_nettype none
`include "chunked_slot_pool_allocator_macros.svh"
module cspa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           opcode,
  input  wire cspa_pkg::cspa_stat_t stat,
  output cspa_pkg::cspa_cmd_t       cmd,
  output logic                      busy,
  output logic                      done
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_SWEEP, S_DIV, S_MEM, S_COMMIT} state_t;
  state_t state;
  logic [1:0] op_q;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && start;
    cmd.init_step = (state == S_SWEEP);
    cmd.div_start = (state == S_READ) || (state == S_SWEEP && stat.init_last);
    cmd.mem_rd    = (state == S_MEM);
    cmd.commit    = (state == S_COMMIT);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      op_q  <= cspa_pkg::OP_INIT;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          busy  <= 1'b1;
          op_q  <= opcode;
          state <= (opcode == cspa_pkg::OP_INIT) ? S_SWEEP : S_READ;
        end
        S_READ:  state <= S_DIV;
        S_SWEEP: if (stat.init_last) state <= S_DIV;
        S_DIV:   if (stat.div_done) state <= S_MEM;
        S_MEM:   state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSPA_ASSERT_IMPL(a_busy_state, clk, rst, state != S_IDLE, busy)
  `CSPA_ASSERT_NEXT(a_commit_done, clk, rst, state == S_COMMIT, done && !busy)
  `CSPA_ASSERT_IMPL(a_sweep_init, clk, rst, state == S_SWEEP, op_q == cspa_pkg::OP_INIT)
endmodule
`default_nettype wire
